// File: sv/hvt_pkg.sv
// ----------------------------------------------------------------------------
// hvt_pkg
// Shared types and constants for the homogeneous vertex transform.
// ----------------------------------------------------------------------------
package hvt_pkg;

  localparam int NUM_LANES  = 4;
  localparam int COEF_W     = 16;
  localparam int COMP_W     = 32;
  localparam int PROD_W     = COEF_W + COMP_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int FRAC_SHIFT = 12;
  localparam int QUOT_W     = ACC_W - FRAC_SHIFT;
  localparam int REG_W      = NUM_LANES * COEF_W;
  localparam int VEC_W      = NUM_LANES * COMP_W;
  localparam int IDX_W      = 2;

  // Reset matrix is the identity, one column per output register
  localparam logic [REG_W-1:0] RESET_OUT_X = 64'h0000_0000_0000_1000;
  localparam logic [REG_W-1:0] RESET_OUT_Y = 64'h0000_0000_1000_0000;
  localparam logic [REG_W-1:0] RESET_OUT_Z = 64'h0000_1000_0000_0000;
  localparam logic [REG_W-1:0] RESET_OUT_W = 64'h1000_0000_0000_0000;

  typedef enum logic [IDX_W-1:0] {
    REG_OUT_X = 2'd0,
    REG_OUT_Y = 2'd1,
    REG_OUT_Z = 2'd2,
    REG_OUT_W = 2'd3
  } reg_idx_t;

  // Stage advance strobes shared by all lanes
  typedef struct packed {
    logic adv1;
    logic adv2;
  } pipe_ctl_t;

endpackage

// File: sv/homogeneous_vertex_transform.sv
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform
// 4x4 matrix times homogeneous vertex, Q16.16 data, Q4.12 coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one vertex per request (x,y,z,w packed from the low bits).
//   m_* returns the transformed vertex; m_tuser flags that at least one
//   component was clipped to the signed 32-bit range.
//   cfg_* writes one 64-bit coefficient register per cycle (index 0..3 for
//   outputs x,y,z,w). Write only while no request is in flight.
// Pipeline: a request passes the product stage, the sum/round/clip stage
//   and the output register, in that order, before it shows on m_tvalid.
// Throughput: one vertex per cycle while m_tready stays high; four lanes
//   with four multipliers each compute all components of a vertex in parallel.
// Reset: clears all valid bits and loads the identity matrix.
// Stall: when m_tready is low the output register holds; empty stages
//   behind it still fill, and s_tready drops only once all stages are full.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform import hvt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // Configuration write port
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]   cfg_data,
  // Input stream
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [VEC_W-1:0]   s_tdata,   // in_x[31:0], in_y[63:32], in_z[95:64], in_w[127:96]
  // Output stream
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [VEC_W-1:0]   m_tdata,   // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
  output logic               m_tuser    // saturated[0]
);

  logic [REG_W-1:0]        coefs [NUM_LANES];
  logic                    v1;
  logic                    v2;
  logic                    take;
  pipe_ctl_t               ctl;
  logic [VEC_W-1:0]        lane_res;
  logic [NUM_LANES-1:0]    lane_sat;

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coefs[0] <= RESET_OUT_X;
      coefs[1] <= RESET_OUT_Y;
      coefs[2] <= RESET_OUT_Z;
      coefs[3] <= RESET_OUT_W;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_OUT_X: coefs[0] <= cfg_data;
        REG_OUT_Y: coefs[1] <= cfg_data;
        REG_OUT_Z: coefs[2] <= cfg_data;
        REG_OUT_W: coefs[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage advance: a stage moves when it is empty or the next one moves
  always_comb begin
    ctl.adv2 = !v2 || take;
    ctl.adv1 = !v1 || ctl.adv2;
  end
  assign s_tready = ctl.adv1;

  // Track valid requests through the lane stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ctl.adv1) v1 <= s_tvalid;
      if (ctl.adv2) v2 <= v1;
    end
  end

  // One lane per output component
  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    logic signed [COMP_W-1:0] res;
    hvt_lane u_lane (
      .clk   (clk),
      .ctl   (ctl),
      .coefs (coefs[c]),
      .vin   (s_tdata),
      .res   (res),
      .sat   (lane_sat[c])
    );
    assign lane_res[COMP_W*c +: COMP_W] = res;
  end

  hvt_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v2),
    .lane_res (lane_res),
    .lane_sat (lane_sat),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: sv/hvt_lane.sv
// ----------------------------------------------------------------------------
// hvt_lane
// One output component: four products, sum, round to nearest, saturate.
// ----------------------------------------------------------------------------
module hvt_lane import hvt_pkg::*; (
  input  logic                     clk,
  input  pipe_ctl_t                ctl,
  input  logic [REG_W-1:0]         coefs,
  input  logic [VEC_W-1:0]         vin,
  output logic signed [COMP_W-1:0] res,
  output logic                     sat
);

  logic signed [PROD_W-1:0] prod [NUM_LANES];
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [QUOT_W-1:0] quot;
  logic [QUOT_W-COMP_W:0]   top_bits;
  logic                     clip;

  // Stage 1: one 16x32 product per input component
  always_ff @(posedge clk) begin
    if (ctl.adv1) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        prod[i] <= $signed(coefs[COEF_W*i +: COEF_W]) * $signed(vin[COMP_W*i +: COMP_W]);
      end
    end
  end

  // Sum, add half an LSB, drop fraction bits (floor), check range
  always_comb begin
    acc = ACC_W'(prod[0]) + ACC_W'(prod[1]) + ACC_W'(prod[2]) + ACC_W'(prod[3]);
    rnd = acc + ACC_W'(signed'(1 << (FRAC_SHIFT - 1)));
    quot = rnd[ACC_W-1:FRAC_SHIFT];
    top_bits = quot[QUOT_W-1:COMP_W-1];
    clip = !((&top_bits) || !(|top_bits));
  end

  // Stage 2: clipped component and flag
  always_ff @(posedge clk) begin
    if (ctl.adv2) begin
      sat <= clip;
      if (clip) begin
        res <= quot[QUOT_W-1] ? {1'b1, {(COMP_W-1){1'b0}}} : {1'b0, {(COMP_W-1){1'b1}}};
      end else begin
        res <= quot[COMP_W-1:0];
      end
    end
  end

endmodule

// File: sv/hvt_merge.sv
// ----------------------------------------------------------------------------
// hvt_merge
// Output register: packs the lane results and combines their clip flags.
// ----------------------------------------------------------------------------
module hvt_merge import hvt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [VEC_W-1:0]       lane_res,
  input  logic [NUM_LANES-1:0]   lane_sat,
  output logic                   take,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [VEC_W-1:0]       m_tdata,
  output logic                   m_tuser
);

  // Load a new request whenever the output slot is free or being drained
  assign take = !m_tvalid || m_tready;

  // Hold valid under reset control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= in_valid;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= lane_res;
      m_tuser <= |lane_sat;
    end
  end

endmodule

// File: sv/hvt_checker.sv
// ----------------------------------------------------------------------------
// hvt_port_checks
// Port-level assertions for the homogeneous vertex transform.
// ----------------------------------------------------------------------------
module hvt_port_checks import hvt_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [VEC_W-1:0] m_tdata,
  input logic             m_tuser
);

  localparam logic [COMP_W-1:0] MAX_VAL = {1'b0, {(COMP_W-1){1'b1}}};
  localparam logic [COMP_W-1:0] MIN_VAL = {1'b1, {(COMP_W-1){1'b0}}};

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // With the output slot empty the input side must take requests
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  // The clip flag needs at least one component at a range limit
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      (m_tdata[31:0] == MAX_VAL) || (m_tdata[31:0] == MIN_VAL) ||
      (m_tdata[63:32] == MAX_VAL) || (m_tdata[63:32] == MIN_VAL) ||
      (m_tdata[95:64] == MAX_VAL) || (m_tdata[95:64] == MIN_VAL) ||
      (m_tdata[127:96] == MAX_VAL) || (m_tdata[127:96] == MIN_VAL))
    else $error("saturated flag without clipped component");

endmodule

bind homogeneous_vertex_transform hvt_port_checks u_hvt_port_checks (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: verif/hvt_checker.sv
// ----------------------------------------------------------------------------
// hvt_checker
// Watches the configuration port and both streams of the vertex transform,
// keeps its own copy of the coefficient matrix, predicts each transformed
// vertex when a request is accepted and compares it, field by field, with
// the oldest pending prediction when a result is accepted.
// ----------------------------------------------------------------------------
module hvt_checker import hvt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [VEC_W-1:0] s_tdata,   // in_x[31:0], in_y[63:32], in_z[95:64], in_w[127:96]
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [VEC_W-1:0] m_tdata,   // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
  input  logic             m_tuser,   // saturated[0]
  output int               mismatches,
  output int               outstanding
);

  // One transformed vertex: clip flag above the four packed components
  typedef struct packed {
    logic                              clipped;
    logic [NUM_LANES-1:0][COMP_W-1:0]  comp;
  } xformed_t;

  logic [REG_W-1:0] matrix_col [NUM_LANES];
  xformed_t         xformed_q [$];

  // Four-term dot product per output lane, round half up, clip to 32 bits
  function automatic xformed_t transform_vertex(input logic [VEC_W-1:0] vtx);
    xformed_t                 res;
    longint                   acc;
    longint                   rounded;
    logic signed [COEF_W-1:0] coef;
    logic signed [COMP_W-1:0] term;
    res = '0;
    for (int lane = 0; lane < NUM_LANES; lane++) begin
      acc = 0;
      for (int i = 0; i < NUM_LANES; i++) begin
        coef = matrix_col[lane][COEF_W*i +: COEF_W];
        term = vtx[COMP_W*i +: COMP_W];
        acc  = acc + longint'(coef) * longint'(term);
      end
      rounded = (acc + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
      if (rounded > 64'sd2147483647) begin
        res.comp[lane] = 32'h7FFF_FFFF;
        res.clipped    = 1'b1;
      end else if (rounded < -64'sd2147483648) begin
        res.comp[lane] = 32'h8000_0000;
        res.clipped    = 1'b1;
      end else begin
        res.comp[lane] = rounded[COMP_W-1:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    xformed_t got;
    xformed_t want;
    if (rst) begin
      matrix_col[0] <= RESET_OUT_X;
      matrix_col[1] <= RESET_OUT_Y;
      matrix_col[2] <= RESET_OUT_Z;
      matrix_col[3] <= RESET_OUT_W;
      xformed_q.delete();
      mismatches = 0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_OUT_X: matrix_col[0] <= cfg_data;
          REG_OUT_Y: matrix_col[1] <= cfg_data;
          REG_OUT_Z: matrix_col[2] <= cfg_data;
          REG_OUT_W: matrix_col[3] <= cfg_data;
          default: ;
        endcase
      end
      // Compare an accepted result with the oldest prediction
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata};
        if (xformed_q.size() == 0) begin
          $display("%0t: result with no request pending, expected none actual %h",
                   $time, got);
          mismatches++;
        end else begin
          want = xformed_q.pop_front();
          for (int lane = 0; lane < NUM_LANES; lane++) begin
            if (got.comp[lane] !== want.comp[lane]) begin
              $display("%0t: lane %0d (x,y,z,w) expected %h actual %h",
                       $time, lane, want.comp[lane], got.comp[lane]);
              mismatches++;
            end
          end
          if (got.clipped !== want.clipped) begin
            $display("%0t: saturated expected %b actual %b",
                     $time, want.clipped, got.clipped);
            mismatches++;
          end
        end
      end
      // Predict each accepted request
      if (s_tvalid && s_tready)
        xformed_q.push_back(transform_vertex(s_tdata));
    end
    outstanding <= xformed_q.size();
  end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the homogeneous vertex transform with directed corner vertices and
// long random streams under several coefficient matrices, with bursty input,
// a patterned output stall and one long output hold-off. The checker module
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import hvt_pkg::*;

  localparam int ITEMS_PER_PHASE = 305;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 6;

  localparam logic [COMP_W-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [COMP_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [COMP_W-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [COMP_W-1:0] Q_NEG = 32'hFFFF_FFFF;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data  = '0;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [VEC_W-1:0] s_tdata   = '0;
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [VEC_W-1:0] m_tdata;
  logic             m_tuser;

  int       mismatches;
  int       outstanding;
  int       burst_left  = 0;
  bit       hold_req    = 1'b0;
  bit       hold_done   = 1'b0;
  int       hold_left   = 0;
  rx_mode_t rx_mode     = RX_FREE;
  int       mode_left   = 0;
  int       rx_tick     = 0;
  int       idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  homogeneous_vertex_transform dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  hvt_checker transform_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Output side: one long hold-off on request, otherwise a changing stall pattern
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 128);
      end
      mode_left--;
      rx_tick++;
      case (rx_mode)
        RX_FREE:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default:   m_tready <= (rx_tick % 3 != 0);
      endcase
    end
  end

  // Abort when nothing moves on either stream for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Mix of extremes, small magnitudes and full-range words
  function automatic logic [COMP_W-1:0] rand_q16();
    logic [COMP_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = Q_MAX;
      1:       v = Q_MIN;
      2:       v = $urandom_range(0, 1) ? '0 : Q_NEG;
      3, 4:    v = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Four packed coefficients, either within +-1.0 or drawn from the corners and random words
  function automatic logic [REG_W-1:0] rand_coef_reg(input bit small_only);
    logic [REG_W-1:0]  r;
    logic [COEF_W-1:0] k;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (small_only) begin
        k = COEF_W'($urandom_range(0, 16'h1FFF) - 16'h1000);
      end else begin
        case ($urandom_range(0, 7))
          0:       k = 16'h7FFF;
          1:       k = 16'h8000;
          2:       k = 16'h0000;
          3:       k = 16'h1000;
          4:       k = 16'hF000;
          default: k = COEF_W'($urandom());
        endcase
      end
      r[COEF_W*i +: COEF_W] = k;
    end
    return r;
  endfunction

  // Offer one request; open a new burst after a random gap when one runs out
  task automatic send_vertex(input logic [VEC_W-1:0] vtx);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= vtx;
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  // Stop offering and wait until every prediction is matched
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write all four coefficient registers while the block is idle
  task automatic load_matrix(input logic [REG_W-1:0] cx, input logic [REG_W-1:0] cy,
                             input logic [REG_W-1:0] cz, input logic [REG_W-1:0] cw);
    logic [REG_W-1:0] cols [NUM_LANES];
    reg_idx_t         idx;
    drain();
    cols = '{cx, cy, cz, cw};
    idx  = REG_OUT_X;
    repeat (NUM_LANES) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= cols[idx];
      idx = idx.next();
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Load a matrix, then stream random vertices with w at 1.0 half the time
  task automatic run_random_phase(input logic [REG_W-1:0] cx, input logic [REG_W-1:0] cy,
                                  input logic [REG_W-1:0] cz, input logic [REG_W-1:0] cw,
                                  input bit hold_off);
    logic [COMP_W-1:0] x, y, z, w;
    load_matrix(cx, cy, cz, cw);
    if (hold_off)
      hold_req = 1'b1;
    repeat (ITEMS_PER_PHASE) begin
      x = rand_q16();
      y = rand_q16();
      z = rand_q16();
      w = $urandom_range(0, 1) ? Q_ONE : rand_q16();
      send_vertex({w, z, y, x});
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Identity matrix from reset: corners pass through unchanged
    send_vertex({Q_ONE, 32'h0, 32'h0, 32'h0});
    send_vertex({Q_MAX, Q_MAX, Q_MAX, Q_MAX});
    send_vertex({Q_MIN, Q_MIN, Q_MIN, Q_MIN});
    send_vertex({Q_ONE, Q_NEG, Q_ONE, Q_NEG});
    send_vertex({32'hFFFF_0000, 32'h0000_FFFF, 32'h8765_4321, 32'h1234_5678});

    // x scaled by one LSB for rounding ties, y/z/w at the coefficient extremes
    load_matrix(64'h0000_0000_0000_0001, 64'h7FFF_7FFF_7FFF_7FFF,
                64'h8000_8000_8000_8000, 64'hFFFF_0001_7FFF_8000);
    send_vertex({32'h0, 32'h0, 32'h0, 32'h0000_0800});
    send_vertex({32'h0, 32'h0, 32'h0, 32'hFFFF_F800});
    send_vertex({32'h0, 32'h0, 32'h0, 32'h0000_1800});
    send_vertex({32'h0, 32'h0, 32'h0, 32'hFFFF_E800});
    send_vertex({32'h0, 32'h0, 32'h0, 32'h0000_07FF});
    send_vertex({32'h0, 32'h0, 32'h0, 32'hFFFF_F7FF});
    send_vertex({32'h0, 32'h0, 32'h0, 32'h0000_0801});
    send_vertex({32'h0, 32'h0, 32'h0, Q_MAX});
    send_vertex({32'h0, 32'h0, 32'h0, Q_MIN});
    send_vertex({Q_MAX, Q_MAX, Q_MAX, Q_MAX});
    send_vertex({Q_MIN, Q_MIN, Q_MIN, Q_MIN});
    send_vertex({Q_MIN, Q_MAX, Q_MIN, Q_MAX});
    send_vertex({Q_ONE, 32'hFFFF_FD00, 32'h0000_0200, 32'h0000_0100});
    send_vertex({32'h0, 32'h0000_0800, 32'h0, 32'h0});
    send_vertex({32'h0000_0800, 32'h0, 32'h0, 32'h0});
    send_vertex({32'h0000_07FF, 32'h0, 32'h0, 32'h0});

    // Random streams under identity, corner, all-max, all-min, small and raw matrices
    run_random_phase(RESET_OUT_X, RESET_OUT_Y, RESET_OUT_Z, RESET_OUT_W, 1'b1);
    run_random_phase(rand_coef_reg(1'b0), rand_coef_reg(1'b0),
                     rand_coef_reg(1'b0), rand_coef_reg(1'b0), 1'b0);
    run_random_phase({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, 1'b0);
    run_random_phase({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 1'b0);
    run_random_phase(rand_coef_reg(1'b1), rand_coef_reg(1'b1),
                     rand_coef_reg(1'b1), rand_coef_reg(1'b1), 1'b0);
    run_random_phase({$urandom(), $urandom()}, {$urandom(), $urandom()},
                     {$urandom(), $urandom()}, {$urandom(), $urandom()}, 1'b0);

    drain();
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
